// ----- design/salc_pkg.sv -----
// Package for the set-associative cache tag unit.
// Holds request/result payload types, config indexes and fixed widths.
package salc_pkg;

    localparam int unsigned AddrW = 64;
    localparam int unsigned AgeW = 16;

    localparam logic [1:0] CFG_TOTAL = 2'd0;
    localparam logic [1:0] CFG_WAYS = 2'd1;
    localparam logic [1:0] CFG_BLOCK = 2'd2;

    localparam logic FUNC_READ = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic             func;
        logic [AddrW-1:0] address;
    } req_t;

    typedef struct packed {
        logic       hit;
        logic       write_back;
        logic [2:0] way;
    } rsp_t;

endpackage

// ----- design/set_assoc_lru_writeback_cache_tags_unit.sv -----
// Top level of the set-associative LRU write-back cache tag unit.
// Uses salc_pkg. Holds one set-wide memory for tags/ages/dirty and valid bits.
//
// Channel   Dir  Handshake           Payload
// req       in   req_valid/req_ready  req_t (func, address)
// rsp       out  rsp_valid/rsp_ready  rsp_t (hit, write_back, way)
// cfg       in   cfg_we               cfg_index, cfg_data
//
// The set memory is read in the cycle a request is taken, the next cycle updates
// and writes back the set, and the result is offered in the cycle after that.
// After reset a clearing pass zeroes all 2^MAX_INDEX_BITS sets; no request is
// taken meanwhile. A new request is taken only once the previous result has
// left its output register, so the unit holds one request at a time, and while
// rsp_ready holds the result off, no new request is taken.
module set_assoc_lru_writeback_cache_tags_unit
    import salc_pkg::*;
#(
    parameter int unsigned MAX_INDEX_BITS = 10,
    parameter int unsigned MAX_WAYS = 8,
    parameter int unsigned ADDR_WIDTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data
);

    localparam int unsigned SetW = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
    localparam int unsigned Sets = 1 << MAX_INDEX_BITS;
    localparam int unsigned WayW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int unsigned EntW = 1 + 1 + ADDR_WIDTH + AgeW;
    localparam int unsigned RowW = EntW * MAX_WAYS;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] total_reg;
    logic [1:0] ways_reg;
    logic [3:0] block_reg;
    logic [SetW-1:0] clr_reg;
    logic [RowW-1:0] mem [Sets];
    logic [RowW-1:0] rd_reg;
    logic [SetW-1:0] set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic wr_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic [ADDR_WIDTH-1:0] addr;
    logic signed [6:0] ib_raw;
    logic [4:0] ibits;
    logic [SetW-1:0] set_c;
    logic [ADDR_WIDTH-1:0] tag_c;
    logic [4:0] nways;

    assign addr = req.address[ADDR_WIDTH-1:0];
    assign ib_raw = $signed({2'b0, total_reg}) - $signed({5'b0, ways_reg})
                    - $signed({3'b0, block_reg});
    always_comb
    begin
        if (ib_raw < 0)
            ibits = '0;
        else if (ib_raw > $signed(7'(MAX_INDEX_BITS)))
            ibits = 5'(MAX_INDEX_BITS);
        else
            ibits = ib_raw[4:0];
        if ((32'd1 << ways_reg) > MAX_WAYS)
            nways = 5'(MAX_WAYS);
        else
            nways = 5'(32'd1 << ways_reg);
    end
    assign set_c = SetW'((addr >> block_reg) & ((ADDR_WIDTH'(1) << ibits) - 1'b1));
    assign tag_c = addr >> (block_reg + ibits);

    assign req_ready = (state_reg == ST_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    // Update logic over the row read from memory.
    logic [RowW-1:0] row_new;
    rsp_t res;
    always_comb
    begin
        logic hit;
        logic found;
        logic [WayW-1:0] hw;
        logic [WayW-1:0] vic;
        logic [AgeW-1:0] vage;
        logic v, d;
        logic [ADDR_WIDTH-1:0] t;
        logic [AgeW-1:0] a;
        hit = 1'b0;
        found = 1'b0;
        hw = '0;
        vic = '0;
        vage = '0;
        row_new = rd_reg;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            {v, d, t, a} = rd_reg[w*EntW +: EntW];
            if (w < nways)
            begin
                if (v && t == tag_reg)
                begin
                    if (!hit)
                        hw = WayW'(w);
                    hit = 1'b1;
                    a = AgeW'(1);
                    d = d | wr_reg;
                end
                else if (a != '1)
                    a = a + 1'b1;
            end
            row_new[w*EntW +: EntW] = {v, d, t, a};
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            {v, d, t, a} = rd_reg[w*EntW +: EntW];
            if (w < nways && !v && !found)
            begin
                vic = WayW'(w);
                found = 1'b1;
            end
        end
        if (!found)
        begin
            vage = row_new[AgeW-1:0];
            for (int w = 1; w < MAX_WAYS; w++)
            begin
                {v, d, t, a} = row_new[w*EntW +: EntW];
                if (w < nways && a > vage)
                begin
                    vic = WayW'(w);
                    vage = a;
                end
            end
        end
        res.hit = hit;
        res.way = 3'(hit ? hw : vic);
        {v, d, t, a} = rd_reg[vic*EntW +: EntW];
        res.write_back = !hit && v && d;
        if (!hit)
            row_new[vic*EntW +: EntW] = {1'b1, wr_reg, tag_reg, AgeW'(1)};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == SetW'(Sets - 1) || Sets == 1) state_next = ST_IDLE;
            ST_IDLE:   if (req_valid && req_ready) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            total_reg <= 5'd15;
            ways_reg <= 2'd1;
            block_reg <= 4'd5;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TOTAL: total_reg <= cfg_data;
                    CFG_WAYS:  ways_reg <= cfg_data[1:0];
                    CFG_BLOCK: block_reg <= cfg_data[3:0];
                    default:   ;
                endcase
            end
            if (state_reg == ST_UPDATE)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            mem[clr_reg] <= '0;
        else if (state_reg == ST_UPDATE)
            mem[set_reg] <= row_new;
        rd_reg <= mem[set_c];
        if (req_valid && req_ready)
        begin
            set_reg <= set_c;
            tag_reg <= tag_c;
            wr_reg <= (req.func == FUNC_WRITE);
        end
        if (state_reg == ST_UPDATE)
            rsp_reg <= res;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |-> !req_ready)
        else $error("request taken during update");
    a_rsp_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |=> rsp_valid)
        else $error("update produced no result");
    a_way_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp.way) < MAX_WAYS)
        else $error("result way out of range");

endmodule

// ----- test/tb_set_assoc_lru_writeback_cache_tags_unit.sv -----
// Self-checking testbench for the set-associative LRU write-back cache tag unit.
// It predicts every result from its own copy of the tag store. It depends on
// salc_pkg and set_assoc_lru_writeback_cache_tags_unit.
module tb_set_assoc_lru_writeback_cache_tags_unit;
    import salc_pkg::*;

    localparam int SETS = 1024;
    localparam int WAYS = 8;
    localparam int CYCLE_LIMIT = 200000;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;

    logic [4:0] size_log;
    logic [1:0] ways_log;
    logic [3:0] block_log;
    logic       line_valid [SETS*WAYS];
    logic       line_dirty [SETS*WAYS];
    logic [63:0] line_tag [SETS*WAYS];
    logic [15:0] line_age [SETS*WAYS];

    rsp_t pending_rsp[$];
    int   errors;
    int   cycles;
    bit   req_idle_on;
    bit   rsp_stall_on;
    int   stall_left;

    set_assoc_lru_writeback_cache_tags_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int index_width();
        int ib;
        ib = int'(size_log) - int'(ways_log) - int'(block_log);
        if (ib < 0)
            ib = 0;
        if (ib > 10)
            ib = 10;
        return ib;
    endfunction

    function automatic rsp_t lookup_and_update(logic func, logic [63:0] addr);
        int ib;
        int nways;
        int base;
        int victim;
        bit found;
        bit hit;
        logic [63:0] set_no;
        logic [63:0] tag;
        rsp_t r;
        ib = index_width();
        nways = 1 << ways_log;
        set_no = (addr >> block_log) & ((64'd1 << ib) - 64'd1);
        tag = addr >> (block_log + ib);
        base = int'(set_no) * WAYS;
        hit = 1'b0;
        victim = 0;
        found = 1'b0;
        r = '0;
        for (int w = 0; w < nways; w++)
        begin
            if (line_valid[base+w] && line_tag[base+w] == tag)
            begin
                if (!hit)
                    r.way = 3'(w);
                hit = 1'b1;
                line_age[base+w] = 16'd1;
                if (func == FUNC_WRITE)
                    line_dirty[base+w] = 1'b1;
            end
            else if (line_age[base+w] != 16'hFFFF)
            begin
                line_age[base+w] = line_age[base+w] + 16'd1;
            end
        end
        if (hit)
        begin
            r.hit = 1'b1;
            return r;
        end
        for (int w = 0; w < nways; w++)
        begin
            if (!found && !line_valid[base+w])
            begin
                victim = w;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            for (int w = 1; w < nways; w++)
            begin
                if (line_age[base+w] > line_age[base+victim])
                    victim = w;
            end
        end
        r.write_back = line_valid[base+victim] && line_dirty[base+victim];
        r.way = 3'(victim);
        line_valid[base+victim] = 1'b1;
        line_age[base+victim] = 16'd1;
        line_tag[base+victim] = tag;
        line_dirty[base+victim] = func;
        return r;
    endfunction

    task automatic access(logic func, logic [63:0] addr);
        if (req_idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req.func <= func;
        req.address <= addr;
        do
            @(posedge clk);
        while (!req_ready);
        pending_rsp.push_back(lookup_and_update(func, addr));
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [4:0] data);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TOTAL)
            size_log = data;
        else if (idx == CFG_WAYS)
            ways_log = data[1:0];
        else if (idx == CFG_BLOCK)
            block_log = data[3:0];
    endtask

    task automatic set_geometry(logic [4:0] ts, logic [4:0] wb, logic [4:0] bb);
        write_cfg(CFG_TOTAL, ts);
        write_cfg(CFG_WAYS, wb);
        write_cfg(CFG_BLOCK, bb);
    endtask

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result without a pending request");
                errors++;
            end
            else
            begin
                if (rsp.hit !== pending_rsp[0].hit)
                begin
                    $error("hit expected %0d actual %0d", pending_rsp[0].hit, rsp.hit);
                    errors++;
                end
                if (rsp.write_back !== pending_rsp[0].write_back)
                begin
                    $error("write_back expected %0d actual %0d",
                           pending_rsp[0].write_back, rsp.write_back);
                    errors++;
                end
                if (rsp.way !== pending_rsp[0].way)
                begin
                    $error("way expected %0d actual %0d", pending_rsp[0].way, rsp.way);
                    errors++;
                end
                void'(pending_rsp.pop_front());
            end
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (rsp_stall_on && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_default_geometry();
        access(FUNC_READ, 64'h0);
        access(FUNC_WRITE, 64'h0000_0000_0000_401F);
        access(FUNC_WRITE, 64'h0000_0000_0001_0000);
        access(FUNC_READ, 64'h0000_0000_0000_8000);
        access(FUNC_READ, 64'h0);
        access(FUNC_READ, 64'hFFFF_FFFF_FFFF_FFFF);
        access(FUNC_WRITE, 64'hFFFF_FFFF_FFFF_FFE0);
        access(FUNC_READ, 64'h7FFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_extreme_geometry();
        set_geometry(5'd0, 5'd0, 5'd0);
        access(FUNC_WRITE, 64'd3);
        access(FUNC_READ, 64'd4);
        access(FUNC_READ, 64'd3);
        set_geometry(5'd31, 5'd3, 5'd31);
        access(FUNC_WRITE, 64'hFFFF_FFFF_FFFF_FFFF);
        access(FUNC_READ, 64'h8000_0000_0000_0000);
        set_geometry(5'd3, 5'd3, 5'd10);
        access(FUNC_READ, 64'h0000_0000_0000_07FF);
        write_cfg(2'd3, 5'd0);
        access(FUNC_READ, 64'h0000_0000_0000_0400);
    endtask

    task automatic test_duplicate_tags();
        set_geometry(5'd0, 5'd1, 5'd0);
        access(FUNC_WRITE, 64'd10);
        access(FUNC_READ, 64'd20);
        write_cfg(CFG_WAYS, 5'd0);
        access(FUNC_READ, 64'd20);
        write_cfg(CFG_WAYS, 5'd1);
        access(FUNC_WRITE, 64'd20);
        access(FUNC_READ, 64'd30);
    endtask

    task automatic test_hot_line();
        set_geometry(5'd2, 5'd2, 5'd0);
        req_idle_on = 1'b0;
        rsp_stall_on = 1'b0;
        for (int a = 100; a < 104; a++)
            access(FUNC_READ, 64'(a));
        access(FUNC_READ, 64'd101);
        repeat (20) access(FUNC_READ, 64'd100);
        access(FUNC_WRITE, 64'd200);
        access(FUNC_READ, 64'd201);
        req_idle_on = 1'b1;
        rsp_stall_on = 1'b1;
    endtask

    task automatic random_phase(logic [4:0] ts, logic [4:0] wb, logic [4:0] bb, int n);
        int ib;
        logic [63:0] tag;
        logic [63:0] set_no;
        logic [63:0] off;
        set_geometry(ts, wb, bb);
        ib = index_width();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                access(1'($urandom), {$urandom, $urandom});
            end
            else
            begin
                tag = $urandom_range(0, 11);
                if ($urandom_range(0, 7) == 0)
                    tag = {$urandom, $urandom};
                set_no = ($urandom_range(0, 7) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3));
                set_no = set_no & ((64'd1 << ib) - 64'd1);
                off = 64'($urandom) & ((64'd1 << block_log) - 64'd1);
                access(1'($urandom), (tag << (block_log + ib)) | (set_no << block_log) | off);
            end
            if (i == n / 2 && $urandom_range(0, 1) == 0)
                wait_idle();
        end
    endtask

    task automatic test_random();
        random_phase(5'd15, 5'd1, 5'd5, 100);
        random_phase(5'd0, 5'd0, 5'd0, 100);
        random_phase(5'd24, 5'd3, 5'd0, 100);
        random_phase(5'd6, 5'd2, 5'd2, 100);
        random_phase(5'd31, 5'd3, 5'd15, 100);
        random_phase(5'd3, 5'd3, 5'd10, 100);
        req_idle_on = 1'b0;
        rsp_stall_on = 1'b0;
        random_phase(5'd8, 5'd1, 5'd3, 100);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        stall_left = 0;
        req_idle_on = 1'b1;
        rsp_stall_on = 1'b1;
        size_log = 5'd15;
        ways_log = 2'd1;
        block_log = 4'd5;
        for (int e = 0; e < SETS * WAYS; e++)
        begin
            line_valid[e] = 1'b0;
            line_dirty[e] = 1'b0;
            line_tag[e] = '0;
            line_age[e] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_default_geometry();
        test_extreme_geometry();
        test_duplicate_tags();
        test_hot_line();
        test_random();
        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
